@@ hdl/msldf_pkg.sv @@
// ----------------------------------------------------------------------------
// msldf_pkg
// Types and constants shared by the sorted-list merge block.
// ----------------------------------------------------------------------------
package msldf_pkg;

  localparam int unsigned LIST_DEPTH_DEF = 16;

  localparam int unsigned ID_W       = 16;
  localparam int unsigned KEY_W      = 32;
  localparam int unsigned S_TDATA_W  = 56;
  localparam int unsigned S_TUSER_W  = 2;
  localparam int unsigned M_TDATA_W  = 48;
  localparam int unsigned M_TUSER_W  = 3;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_RUN  = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]         id;
    logic signed [KEY_W-1:0] key;
    logic                    drop;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MERGE,
    ST_FLUSH
  } state_e;

endpackage

@@ hdl/msldf_list_mem.sv @@
// ----------------------------------------------------------------------------
// msldf_list_mem
// One list store: single write port, one synchronous read port.
// ----------------------------------------------------------------------------
module msldf_list_mem #(
  parameter int unsigned DEPTH = msldf_pkg::LIST_DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  msldf_pkg::entry_t wdata_i,
  input  logic [AW-1:0]     raddr_i,
  output msldf_pkg::entry_t rdata_o
);
  import msldf_pkg::*;

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/msldf_merge_ctrl.sv @@
// ----------------------------------------------------------------------------
// msldf_merge_ctrl
// Load sequencing, merge walk over both stores, pending slot and output reg.
// ----------------------------------------------------------------------------
module msldf_merge_ctrl #(
  parameter int unsigned DEPTH = msldf_pkg::LIST_DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input stream
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          opcode_i,
  input  logic                          list_select_i,
  input  msldf_pkg::entry_t             in_entry_i,
  // store ports
  output logic                          we0_o,
  output logic                          we1_o,
  output logic [AW-1:0]                 waddr_o,
  output msldf_pkg::entry_t             wdata_o,
  output logic [AW-1:0]                 raddr0_o,
  output logic [AW-1:0]                 raddr1_o,
  input  msldf_pkg::entry_t             rdata0_i,
  input  msldf_pkg::entry_t             rdata1_i,
  // result stream
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output msldf_pkg::entry_t             out_entry_o,
  output logic                          out_from_second_o,
  output logic                          out_empty_o,
  output logic                          out_ovf_o,
  output logic                          out_last_o
);
  import msldf_pkg::*;

  state_e        state_q, state_d;
  logic [CW-1:0] cnt0_q, cnt0_d, cnt1_q, cnt1_d;
  logic [CW-1:0] p0_q, p0_d, p1_q, p1_d;
  logic          ovf_q, ovf_d;
  logic          pend_v_q, pend_v_d;
  entry_t        pend_q, pend_d;
  logic          pend_from2_q, pend_from2_d;
  logic          out_v_q, out_v_d;
  entry_t        out_ent_q, out_ent_d;
  logic          out_from2_q, out_from2_d;
  logic          out_empty_q, out_empty_d;
  logic          out_ovf_q, out_ovf_d;
  logic          out_last_q, out_last_d;

  logic          accept, out_free, have0, have1, take1, keep, stall;
  entry_t        sel_ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt0_q   <= '0;
      cnt1_q   <= '0;
      p0_q     <= '0;
      p1_q     <= '0;
      ovf_q    <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt0_q   <= cnt0_d;
      cnt1_q   <= cnt1_d;
      p0_q     <= p0_d;
      p1_q     <= p1_d;
      ovf_q    <= ovf_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q       <= pend_d;
    pend_from2_q <= pend_from2_d;
    out_ent_q    <= out_ent_d;
    out_from2_q  <= out_from2_d;
    out_empty_q  <= out_empty_d;
    out_ovf_q    <= out_ovf_d;
    out_last_q   <= out_last_d;
  end

  always_comb begin
    state_d      = state_q;
    cnt0_d       = cnt0_q;
    cnt1_d       = cnt1_q;
    p0_d         = p0_q;
    p1_d         = p1_q;
    ovf_d        = ovf_q;
    pend_v_d     = pend_v_q;
    pend_d       = pend_q;
    pend_from2_d = pend_from2_q;
    out_v_d      = out_v_q;
    out_ent_d    = out_ent_q;
    out_from2_d  = out_from2_q;
    out_empty_d  = out_empty_q;
    out_ovf_d    = out_ovf_q;
    out_last_d   = out_last_q;

    we0_o    = 1'b0;
    we1_o    = 1'b0;
    waddr_o  = list_select_i ? cnt1_q[AW-1:0] : cnt0_q[AW-1:0];
    wdata_o  = in_entry_i;
    raddr0_o = '0;
    raddr1_o = '0;

    in_ready_o = (state_q == ST_IDLE);
    accept     = in_valid_i && in_ready_o;
    out_free   = !out_v_q || out_ready_i;
    have0      = (p0_q < cnt0_q);
    have1      = (p1_q < cnt1_q);
    take1      = have1 && (!have0 || ($signed(rdata0_i.key) < $signed(rdata1_i.key)));
    sel_ent    = take1 ? rdata1_i : rdata0_i;
    keep       = !sel_ent.drop;
    stall      = keep && pend_v_q && !out_free;

    if (out_v_q && out_ready_i) begin
      out_v_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (opcode_i == OP_LOAD) begin
            if (!list_select_i) begin
              // drop loads into a full list
              if (cnt0_q == CW'(DEPTH)) begin
                ovf_d = 1'b1;
              end else begin
                we0_o  = 1'b1;
                cnt0_d = cnt0_q + CW'(1);
              end
            end else begin
              if (cnt1_q == CW'(DEPTH)) begin
                ovf_d = 1'b1;
              end else begin
                we1_o  = 1'b1;
                cnt1_d = cnt1_q + CW'(1);
              end
            end
          end else begin
            p0_d    = '0;
            p1_d    = '0;
            state_d = ST_MERGE;
          end
        end
      end

      ST_MERGE: begin
        raddr0_o = p0_q[AW-1:0];
        raddr1_o = p1_q[AW-1:0];
        if (!have0 && !have1) begin
          state_d = ST_FLUSH;
        end else if (!stall) begin
          // advance the consumed list and prefetch its next entry
          if (take1) begin
            p1_d     = p1_q + CW'(1);
            raddr1_o = p1_d[AW-1:0];
          end else begin
            p0_d     = p0_q + CW'(1);
            raddr0_o = p0_d[AW-1:0];
          end
          if (keep) begin
            if (pend_v_q) begin
              out_v_d     = 1'b1;
              out_ent_d   = pend_q;
              out_from2_d = pend_from2_q;
              out_empty_d = 1'b0;
              out_ovf_d   = ovf_q;
              out_last_d  = 1'b0;
            end
            pend_v_d     = 1'b1;
            pend_d       = sel_ent;
            pend_from2_d = take1;
          end
        end
      end

      ST_FLUSH: begin
        if (out_free) begin
          out_v_d    = 1'b1;
          out_ovf_d  = ovf_q;
          out_last_d = 1'b1;
          if (pend_v_q) begin
            out_ent_d   = pend_q;
            out_from2_d = pend_from2_q;
            out_empty_d = 1'b0;
          end else begin
            out_ent_d   = '0;
            out_from2_d = 1'b0;
            out_empty_d = 1'b1;
          end
          pend_v_d = 1'b0;
          cnt0_d   = '0;
          cnt1_d   = '0;
          ovf_d    = 1'b0;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o       = out_v_q;
  assign out_entry_o       = out_ent_q;
  assign out_from_second_o = out_from2_q;
  assign out_empty_o       = out_empty_q;
  assign out_ovf_o         = out_ovf_q;
  assign out_last_o        = out_last_q;

`ifndef SYNTHESIS
  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_v_q)
    else $error("pending result left over outside a merge run");

  a_ptr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MERGE) |-> ((p0_q <= cnt0_q) && (p1_q <= cnt1_q)))
    else $error("merge pointer ran past its list count");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt0_q <= CW'(DEPTH)) && (cnt1_q <= CW'(DEPTH)))
    else $error("list count exceeds store depth");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_empty_q) |-> (out_last_q && (out_ent_q == '0) && !out_from2_q))
    else $error("empty result must be the last one and carry zero fields");

  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_FLUSH) && out_free) |=> ((cnt0_q == '0) && (cnt1_q == '0) && !ovf_q))
    else $error("counts or overflow not cleared after run");
`endif

endmodule

@@ hdl/merge_sorted_lists_drop_flagged.sv @@
// ----------------------------------------------------------------------------
// merge_sorted_lists_drop_flagged
// Two descending-key lists loaded entry by entry, merged on a run command.
// ----------------------------------------------------------------------------
// Load: one load per cycle while no run is in progress, no result.
// Run: entry 0 of both stores is read on the accept edge, then one stored
//   entry is consumed per cycle unless the output stalls; once both lists are
//   exhausted a flush step follows; a kept entry leaves the cycle after
//   the next kept entry is consumed, the final one the cycle after the flush.
// Reset: counts, overflow flag and control clear at once; stores stay as is.
module merge_sorted_lists_drop_flagged #(
  parameter int unsigned LIST_DEPTH = msldf_pkg::LIST_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // entry_id[15:0], key[47:16], drop_flag[48], zero[55:49]
  input  logic [msldf_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // opcode[0], list_select[1]
  input  logic [msldf_pkg::S_TUSER_W-1:0]  s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // out_id[15:0], out_key[47:16]
  output logic [msldf_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // from_second[0], is_empty[1], overflowed[2]
  output logic [msldf_pkg::M_TUSER_W-1:0]  m_axis_tuser,
  output logic                             m_axis_tlast
);
  import msldf_pkg::*;

  localparam int unsigned AW = $clog2(LIST_DEPTH);
  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);

  entry_t        in_entry, wdata, rdata0, rdata1, out_entry;
  logic          we0, we1;
  logic [AW-1:0] waddr, raddr0, raddr1;
  logic          out_from_second, out_empty, out_ovf;

  assign in_entry.id   = s_axis_tdata[15:0];
  assign in_entry.key  = s_axis_tdata[47:16];
  assign in_entry.drop = s_axis_tdata[48];

  msldf_list_mem #(
    .DEPTH (LIST_DEPTH),
    .AW    (AW)
  ) u_first_mem (
    .clk_i   (clk_i),
    .we_i    (we0),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr0),
    .rdata_o (rdata0)
  );

  msldf_list_mem #(
    .DEPTH (LIST_DEPTH),
    .AW    (AW)
  ) u_second_mem (
    .clk_i   (clk_i),
    .we_i    (we1),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr1),
    .rdata_o (rdata1)
  );

  msldf_merge_ctrl #(
    .DEPTH (LIST_DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (s_axis_tvalid),
    .in_ready_o        (s_axis_tready),
    .opcode_i          (s_axis_tuser[0]),
    .list_select_i     (s_axis_tuser[1]),
    .in_entry_i        (in_entry),
    .we0_o             (we0),
    .we1_o             (we1),
    .waddr_o           (waddr),
    .wdata_o           (wdata),
    .raddr0_o          (raddr0),
    .raddr1_o          (raddr1),
    .rdata0_i          (rdata0),
    .rdata1_i          (rdata1),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready),
    .out_entry_o       (out_entry),
    .out_from_second_o (out_from_second),
    .out_empty_o       (out_empty),
    .out_ovf_o         (out_ovf),
    .out_last_o        (m_axis_tlast)
  );

  assign m_axis_tdata = {out_entry.key, out_entry.id};
  assign m_axis_tuser = {out_ovf, out_empty, out_from_second};

endmodule

@@ bench/tb_merge_sorted_lists_drop_flagged.sv @@
// ----------------------------------------------------------------------------
// tb_merge_sorted_lists_drop_flagged
// Self-checking bench for the two-list descending merge with flagged entries
// dropped. A short table of directed items comes first, then random batches:
// mostly sorted list pairs followed by a run, with overfilled lists, fully
// dropped lists and unsorted noise mixed in. Both stream sides idle and stall
// at random. A local predictor of the two lists builds the expected result
// items, which are compared field by field as they leave the block.
// ----------------------------------------------------------------------------
module tb_merge_sorted_lists_drop_flagged;
  import msldf_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int ITEM_GOAL    = 310;
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int MAX_LOADS    = 20;

  localparam logic LIST_FIRST  = 1'b0;
  localparam logic LIST_SECOND = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] key;
    logic             from_second;
    logic             is_empty;
    logic             overflowed;
    logic             last;
  } result_t;

  typedef enum logic {
    CHK_MODEL,
    CHK_EMPTY
  } chk_e;

  typedef struct packed {
    logic             op;
    logic             sel;
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] key;
    logic             drop;
    chk_e             chk;
  } step_t;

  localparam result_t EMPTY_RUN = '{id: '0, key: '0, from_second: 1'b0, is_empty: 1'b1,
                                    overflowed: 1'b0, last: 1'b1};

  localparam int N_DIRECTED = 21;
  localparam step_t DIRECTED [N_DIRECTED] = '{
    '{OP_RUN,  LIST_FIRST,  16'h0000, 32'h0000_0000, 1'b0, CHK_EMPTY},
    '{OP_LOAD, LIST_FIRST,  16'hFFFF, 32'h7FFF_FFFF, 1'b0, CHK_MODEL},
    '{OP_LOAD, LIST_SECOND, 16'h0000, 32'h7FFF_FFFF, 1'b0, CHK_MODEL},
    '{OP_LOAD, LIST_FIRST,  16'h0001, 32'h0001_0000, 1'b1, CHK_MODEL},
    '{OP_LOAD, LIST_SECOND, 16'h8000, 32'h0000_0000, 1'b0, CHK_MODEL},
    '{OP_LOAD, LIST_FIRST,  16'h0002, 32'h0000_0000, 1'b0, CHK_MODEL},
    '{OP_LOAD, LIST_SECOND, 16'h1234, 32'hFFFF_0000, 1'b1, CHK_MODEL},
    '{OP_LOAD, LIST_FIRST,  16'hAAAA, 32'h8000_0000, 1'b0, CHK_MODEL},
    '{OP_LOAD, LIST_SECOND, 16'h5555, 32'h8000_0000, 1'b0, CHK_MODEL},
    '{OP_RUN,  LIST_SECOND, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, CHK_MODEL},
    '{OP_LOAD, LIST_SECOND, 16'h0007, 32'h0005_0000, 1'b0, CHK_MODEL},
    '{OP_LOAD, LIST_SECOND, 16'h0008, 32'h0000_0001, 1'b0, CHK_MODEL},
    '{OP_RUN,  LIST_FIRST,  16'h0000, 32'h0000_0000, 1'b0, CHK_MODEL},
    '{OP_LOAD, LIST_FIRST,  16'h0009, 32'h7FFF_FFFF, 1'b1, CHK_MODEL},
    '{OP_LOAD, LIST_SECOND, 16'h000A, 32'h8000_0000, 1'b1, CHK_MODEL},
    '{OP_RUN,  LIST_FIRST,  16'h0000, 32'h0000_0000, 1'b0, CHK_EMPTY},
    // unsorted first list: merge rule applies unchecked
    '{OP_LOAD, LIST_FIRST,  16'h000B, 32'h0000_0010, 1'b0, CHK_MODEL},
    '{OP_LOAD, LIST_FIRST,  16'h000C, 32'h0000_0020, 1'b0, CHK_MODEL},
    '{OP_LOAD, LIST_SECOND, 16'h000D, 32'h0000_0018, 1'b0, CHK_MODEL},
    '{OP_RUN,  LIST_FIRST,  16'h0000, 32'h0000_0000, 1'b0, CHK_MODEL},
    '{OP_RUN,  LIST_SECOND, 16'h0000, 32'h0000_0000, 1'b0, CHK_EMPTY}
  };

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  // entry_id[15:0], key[47:16], drop_flag[48], zero[55:49]
  logic [S_TDATA_W-1:0] s_axis_tdata;
  // opcode[0], list_select[1]
  logic [S_TUSER_W-1:0] s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // out_id[15:0], out_key[47:16]
  logic [M_TDATA_W-1:0] m_axis_tdata;
  // from_second[0], is_empty[1], overflowed[2]
  logic [M_TUSER_W-1:0] m_axis_tuser;
  logic                 m_axis_tlast;

  // predictor state
  entry_t  first_list  [LIST_DEPTH_DEF];
  entry_t  second_list [LIST_DEPTH_DEF];
  int      first_n   = 0;
  int      second_n  = 0;
  logic    lost_load = 1'b0;
  result_t merged_due [$];

  int items_sent  = 0;
  int errors      = 0;
  int cycle_count = 0;
  bit src_calm    = 1'b0;
  bit sink_calm   = 1'b0;
  int sink_hold   = 0;

  merge_sorted_lists_drop_flagged #(
    .LIST_DEPTH(LIST_DEPTH_DEF)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Mostly short pauses, a few long ones, none while calm.
  function automatic int pause_len(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Next key of a descending list, with ties and clamping at the minimum.
  function automatic logic [KEY_W-1:0] descend(input logic [KEY_W-1:0] prev);
    longint k;
    case ($urandom_range(0, 3))
      0: k = longint'($signed(prev));
      1: k = longint'($signed(prev)) - longint'($urandom_range(1, 3));
      2: k = longint'($signed(prev)) - longint'($urandom_range(1, 32'h00FF_FFFF));
      default: k = longint'($signed(prev)) - longint'($urandom_range(1, 32'h7FFF_FFFF));
    endcase
    if (k < -64'sd2147483648) k = -64'sd2147483648;
    return k[KEY_W-1:0];
  endfunction

  // Apply one accepted item to the list copies; a run queues the merged items when emit is set.
  function automatic void apply_to_lists(input logic op, input logic sel,
                                         input logic [ID_W-1:0] id,
                                         input logic [KEY_W-1:0] key,
                                         input logic drop, input bit emit);
    entry_t  e;
    result_t held;
    bit      have_held;
    bit      take_first;
    int      p0;
    int      p1;
    e.id   = id;
    e.key  = key;
    e.drop = drop;
    if (op == OP_LOAD) begin
      if (sel == LIST_SECOND) begin
        if (second_n >= LIST_DEPTH_DEF) lost_load = 1'b1;
        else begin
          second_list[second_n] = e;
          second_n++;
        end
      end else begin
        if (first_n >= LIST_DEPTH_DEF) lost_load = 1'b1;
        else begin
          first_list[first_n] = e;
          first_n++;
        end
      end
      return;
    end
    p0 = 0;
    p1 = 0;
    have_held = 1'b0;
    held = '0;
    while (p0 < first_n || p1 < second_n) begin
      // first list wins ties
      take_first = p0 < first_n &&
                   (p1 >= second_n ||
                    $signed(first_list[p0].key) >= $signed(second_list[p1].key));
      if (take_first) begin
        e = first_list[p0];
        p0++;
      end else begin
        e = second_list[p1];
        p1++;
      end
      if (!e.drop) begin
        if (have_held && emit) merged_due = {merged_due, held};
        held = '{id: e.id, key: e.key, from_second: !take_first, is_empty: 1'b0,
                 overflowed: lost_load, last: 1'b0};
        have_held = 1'b1;
      end
    end
    if (!have_held) begin
      held = '{id: '0, key: '0, from_second: 1'b0, is_empty: 1'b1,
               overflowed: lost_load, last: 1'b1};
    end
    held.last = 1'b1;
    if (emit) merged_due = {merged_due, held};
    first_n   = 0;
    second_n  = 0;
    lost_load = 1'b0;
  endfunction

  task automatic send_item(input logic op, input logic sel, input logic [ID_W-1:0] id,
                           input logic [KEY_W-1:0] key, input logic drop,
                           input bit typed_empty);
    logic [S_TDATA_W-1:0] word;
    int gap;
    word = '0;
    word[ID_W-1:0]          = id;
    word[ID_W+KEY_W-1:ID_W] = key;
    word[ID_W+KEY_W]        = drop;
    gap = pause_len(src_calm);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= {sel, op};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    apply_to_lists(op, sel, id, key, drop, !typed_empty);
    if (typed_empty) merged_due = {merged_due, EMPTY_RUN};
    items_sent++;
  endtask

  function automatic void note_mismatch(input string what, input result_t want,
                                        input result_t got);
    errors++;
    if (errors <= 10) begin
      $display("%s: want id=%h key=%h sec=%b emp=%b ovf=%b last=%b", what, want.id,
               want.key, want.from_second, want.is_empty, want.overflowed, want.last);
      $display("%s:  got id=%h key=%h sec=%b emp=%b ovf=%b last=%b", what, got.id,
               got.key, got.from_second, got.is_empty, got.overflowed, got.last);
    end
  endfunction

  // Result sink: random stalls, with calm stretches.
  always @(posedge clk_i) begin
    if (sink_hold > 0) begin
      m_axis_tready <= 1'b0;
      sink_hold     <= sink_hold - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 127) == 0) sink_calm <= ~sink_calm;
      if (!sink_calm && $urandom_range(0, 3) == 0) sink_hold <= pause_len(1'b0);
    end
  end

  always @(posedge clk_i) begin : result_check
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{id: m_axis_tdata[ID_W-1:0], key: m_axis_tdata[ID_W+KEY_W-1:ID_W],
              from_second: m_axis_tuser[0], is_empty: m_axis_tuser[1],
              overflowed: m_axis_tuser[2], last: m_axis_tlast};
      if (merged_due.size() == 0) note_mismatch("unexpected item", '0, got);
      else begin
        want = merged_due.pop_front();
        if (got !== want) note_mismatch("mismatch", want, got);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_merge_sorted_lists_drop_flagged failed");
      $finish;
    end
  end

  initial begin
    logic [KEY_W-1:0] keys_a [MAX_LOADS];
    logic [KEY_W-1:0] keys_b [MAX_LOADS];
    int   n_a;
    int   n_b;
    int   i_a;
    int   i_b;
    int   drop_mode;
    int   burst;
    logic pick_b;
    logic drop;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIRECTED[i]) begin
      send_item(DIRECTED[i].op, DIRECTED[i].sel, DIRECTED[i].id, DIRECTED[i].key,
                DIRECTED[i].drop, DIRECTED[i].chk == CHK_EMPTY);
    end

    while (items_sent < ITEM_GOAL) begin
      if ($urandom_range(0, 3) == 0) src_calm = ~src_calm;
      if ($urandom_range(0, 4) == 0) begin
        // noise: any opcode, any list, unsorted keys
        burst = $urandom_range(1, 5);
        repeat (burst) begin
          send_item(($urandom_range(0, 3) == 0) ? OP_RUN : OP_LOAD, 1'($urandom),
                    16'($urandom), $urandom, 1'($urandom), 1'b0);
        end
      end else begin
        // sorted pair of lists, sometimes past full, then a run
        n_a = ($urandom_range(0, 7) == 0) ? $urandom_range(17, MAX_LOADS)
                                          : $urandom_range(0, LIST_DEPTH_DEF);
        n_b = ($urandom_range(0, 7) == 0) ? $urandom_range(17, MAX_LOADS)
                                          : $urandom_range(0, LIST_DEPTH_DEF);
        drop_mode = $urandom_range(0, 7);
        keys_a[0] = ($urandom_range(0, 3) == 0) ? 32'h7FFF_FFFF : $urandom;
        keys_b[0] = ($urandom_range(0, 1) == 0) ? keys_a[0] : $urandom;
        for (int k = 1; k < MAX_LOADS; k++) begin
          keys_a[k] = descend(keys_a[k-1]);
          keys_b[k] = descend(keys_b[k-1]);
        end
        i_a = 0;
        i_b = 0;
        while (i_a < n_a || i_b < n_b) begin
          pick_b = (i_a >= n_a) || (i_b < n_b && $urandom_range(0, 1) == 1);
          case (drop_mode)
            0, 1:    drop = 1'b0;
            7:       drop = 1'b1;
            default: drop = ($urandom_range(0, 3) == 0);
          endcase
          if (pick_b) begin
            send_item(OP_LOAD, LIST_SECOND, 16'($urandom), keys_b[i_b], drop, 1'b0);
            i_b++;
          end else begin
            send_item(OP_LOAD, LIST_FIRST, 16'($urandom), keys_a[i_a], drop, 1'b0);
            i_a++;
          end
        end
        send_item(OP_RUN, 1'($urandom), 16'($urandom), $urandom, 1'($urandom), 1'b0);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (merged_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && merged_due.size() == 0) begin
      $display("tb_merge_sorted_lists_drop_flagged passed");
    end else begin
      $display("tb_merge_sorted_lists_drop_flagged failed");
    end
    $finish;
  end

endmodule

@@ merge_sorted_lists_drop_flagged.f @@
hdl/msldf_pkg.sv
hdl/msldf_list_mem.sv
hdl/msldf_merge_ctrl.sv
hdl/merge_sorted_lists_drop_flagged.sv
bench/tb_merge_sorted_lists_drop_flagged.sv
